// File: rtl/morton_3d_domain_skip_top_defines.svh
// Assertion macros shared by the Morton domain skip block.
`ifndef MORTON_3D_DOMAIN_SKIP_TOP_DEFINES_SVH
`define MORTON_3D_DOMAIN_SKIP_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define M3DS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define M3DS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/m3ds_pkg.sv
// Shared types and constants of the Morton domain skip block.
`default_nettype none

package m3ds_pkg;

    localparam int REG_W     = 21;
    localparam int STEPS_W   = 16;
    localparam int CODE_W    = 63;
    localparam int TDATA_W   = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 3'd6;

    localparam logic [REG_W-1:0]   MIN_RESET   = 21'd0;
    localparam logic [REG_W-1:0]   MAX_RESET   = 21'h1FFFFF;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 16'd64;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic find;
        logic add;
        logic next_axis;
        logic clamp;
        logic push;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic any_ex;
        logic ex_cur;
        logic axis_first;
        logic round_limit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/m3ds_datapath.sv
// Datapath of the Morton domain skip block: registers, decode, skip adder and clamp.
`default_nettype none

module m3ds_datapath import m3ds_pkg::*; #(
    parameter int AXIS_BITS = 21
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data,
    input  wire logic [TDATA_W-1:0]   s_tdata,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_W-1:0]        m_tdata
);

    localparam int CODE_BITS = 3 * AXIS_BITS;

    logic [REG_W-1:0]     min_x_reg, min_y_reg, min_z_reg;
    logic [REG_W-1:0]     max_x_reg, max_y_reg, max_z_reg;
    logic [STEPS_W-1:0]   max_steps_reg;

    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [AXIS_BITS-1:0] onehot_reg;
    axis_t                axis_reg, axis_next;
    logic [STEPS_W-1:0]   round_reg, round_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]   m_tdata_reg;

    logic [AXIS_BITS-1:0] x_idx, y_idx, z_idx;
    logic [AXIS_BITS-1:0] x_cl, y_cl, z_cl;
    logic [AXIS_BITS-1:0] digit_nz, digit_low;
    logic [REG_W-1:0]     x_ext, y_ext, z_ext;
    logic [2:0]           ex;
    logic [2:0]           unit;
    logic [CODE_BITS-1:0] add_val, clamp_code;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg     <= MIN_RESET;
            min_y_reg     <= MIN_RESET;
            min_z_reg     <= MIN_RESET;
            max_x_reg     <= MAX_RESET;
            max_y_reg     <= MAX_RESET;
            max_z_reg     <= MAX_RESET;
            max_steps_reg <= STEPS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_X:     min_x_reg     <= cfg_data;
                CFG_MIN_Y:     min_y_reg     <= cfg_data;
                CFG_MIN_Z:     min_z_reg     <= cfg_data;
                CFG_MAX_X:     max_x_reg     <= cfg_data;
                CFG_MAX_Y:     max_y_reg     <= cfg_data;
                CFG_MAX_Z:     max_z_reg     <= cfg_data;
                CFG_MAX_STEPS: max_steps_reg <= cfg_data[STEPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // De-interleave the current code and find the lowest nonzero octal digit.
    always_comb begin
        for (int i = 0; i < AXIS_BITS; i++) begin
            x_idx[i]    = code_reg[3*i];
            y_idx[i]    = code_reg[3*i+1];
            z_idx[i]    = code_reg[3*i+2];
            digit_nz[i] = |code_reg[3*i +: 3];
        end
    end

    assign digit_low = digit_nz & (~digit_nz + AXIS_BITS'(1));

    assign x_ext = REG_W'(x_idx);
    assign y_ext = REG_W'(y_idx);
    assign z_ext = REG_W'(z_idx);

    assign ex = {z_ext > max_z_reg, y_ext > max_y_reg, x_ext > max_x_reg};

    always_comb begin
        case (axis_reg)
            AXIS_X:  unit = 3'b001;
            AXIS_Y:  unit = 3'b010;
            AXIS_Z:  unit = 3'b100;
            default: unit = 3'b000;
        endcase
    end

    always_comb begin
        for (int k = 0; k < AXIS_BITS; k++) begin
            add_val[3*k +: 3] = onehot_reg[k] ? unit : 3'b000;
        end
    end

    // Raise each axis below its minimum, then interleave again.
    assign x_cl = (x_ext < min_x_reg) ? min_x_reg[AXIS_BITS-1:0] : x_idx;
    assign y_cl = (y_ext < min_y_reg) ? min_y_reg[AXIS_BITS-1:0] : y_idx;
    assign z_cl = (z_ext < min_z_reg) ? min_z_reg[AXIS_BITS-1:0] : z_idx;

    always_comb begin
        for (int i = 0; i < AXIS_BITS; i++) begin
            clamp_code[3*i]   = x_cl[i];
            clamp_code[3*i+1] = y_cl[i];
            clamp_code[3*i+2] = z_cl[i];
        end
    end

    always_comb begin
        code_next = code_reg;
        if (cmd.load) begin
            code_next = s_tdata[CODE_BITS-1:0];
        end else if (cmd.add) begin
            code_next = code_reg + add_val;
        end else if (cmd.clamp) begin
            code_next = clamp_code;
        end
    end

    always_comb begin
        axis_next  = axis_reg;
        round_next = round_reg;
        if (cmd.load) begin
            axis_next  = AXIS_X;
            round_next = '0;
        end else if (cmd.next_axis) begin
            if (axis_reg == AXIS_Z) begin
                axis_next  = AXIS_X;
                round_next = round_reg + STEPS_W'(1);
            end else begin
                axis_next = axis_reg + 2'd1;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg     <= AXIS_X;
            round_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            axis_reg     <= axis_next;
            round_reg    <= round_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        if (cmd.find) begin
            onehot_reg <= digit_low;
        end
        if (cmd.push) begin
            m_tdata_reg <= TDATA_W'(code_reg);
        end
    end

    always_comb begin
        status.any_ex      = |ex;
        status.axis_first  = (axis_reg == AXIS_X);
        status.round_limit = (round_reg == max_steps_reg);
        status.out_free    = !m_tvalid_reg || m_tready;
        case (axis_reg)
            AXIS_X:  status.ex_cur = ex[0];
            AXIS_Y:  status.ex_cur = ex[1];
            AXIS_Z:  status.ex_cur = ex[2];
            default: status.ex_cur = 1'b0;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: rtl/m3ds_ctrl.sv
// Controller state machine of the Morton domain skip block.
`default_nettype none

module m3ds_ctrl import m3ds_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_FIND  = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_CLAMP = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // A new round starts only while some axis still exceeds.
                if (status.axis_first && (!status.any_ex || status.round_limit)) begin
                    state_next = ST_CLAMP;
                end else if (status.ex_cur) begin
                    state_next = ST_FIND;
                end else begin
                    cmd.next_axis = 1'b1;
                end
            end
            ST_FIND: begin
                cmd.find   = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add       = 1'b1;
                cmd.next_axis = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/morton_3d_domain_skip_top.sv
// Top level of the Morton domain skip block: controller, datapath and checks.
//
// A request on the slave stream carries one 3D Morton code in s_tdata; the block
// moves it toward the box set by the configuration registers and returns one code
// on the master stream. Registers are written through cfg_we, cfg_index and
// cfg_data, one register per cycle; the user must write them only while the block
// is idle, which the block itself does not enforce. One request is worked on at a
// time. After acceptance each skip round checks the three axes in turn and steps
// every axis that exceeds its maximum (digit search, then add and decode). At
// most max_steps rounds run, and a code already inside the box skips them; then
// the clamp raises any axis below its minimum, and the result register is loaded
// once the output register is free.
// The result sits in an output register, so the next request is accepted while
// the previous result still waits for m_tready; a stalled receiver only holds
// the block once a second result is ready and cannot be stored.
// A synchronous low aresetn returns the block to idle, empties the output
// register and restores the register defaults (no minimum, full maximum, 64
// rounds).
`default_nettype none

`include "morton_3d_domain_skip_top_defines.svh"

module morton_3d_domain_skip_top import m3ds_pkg::*; #(
    parameter int AXIS_BITS = 21
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_W-1:0]   s_tdata,   // [62:0] code_in, [63] zero
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_W-1:0]        m_tdata    // [62:0] code_out, [63] zero
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences rounds and axes; it sees the datapath only
    // through the command and status structures.
    m3ds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the registers, the working code, the skip adder,
    // the clamp and the output register.
    m3ds_datapath #(
        .AXIS_BITS (AXIS_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Once a request is taken the block is busy until its result is pushed.
    `M3DS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    // A result is only pushed into a free output register.
    `M3DS_ASSERT_NOW(a_push_free, cmd.push, !m_tvalid || m_tready, "push over held result")
    // A push always shows a valid result in the next cycle.
    `M3DS_ASSERT_NEXT(a_push_valid, cmd.push, m_tvalid, "pushed result not shown")
    // The datapath never gets two conflicting writes of the working code.
    `M3DS_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({cmd.load, cmd.find, cmd.add, cmd.clamp, cmd.push}), "command clash")

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the 3D Morton domain skip block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import m3ds_pkg::*;

    // The block is built with full 21-bit axes, so a code fills 63 bits.
    localparam int AXIS_BITS = 21;

    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [AXIS_BITS-1:0] coord_t;

    localparam code_t CODE_FULL = {CODE_W{1'b1}};
    localparam code_t REG_TOP   = code_t'(MAX_RESET);
    localparam code_t STEPS_TOP = 63'hFFFF;

    // Limit on cycles in which no request moves on either side; only a stuck
    // handshake can reach it.
    localparam int WATCHDOG_LIMIT  = 10000;
    // Pause before a register write and after the last result.
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 64;
    // Length of the deliberate receiver hold-off that fills the block up.
    localparam int HOLD_OFF_CYCLES = 300;
    // Random phases and requests per phase.
    localparam int PHASES          = 8;
    localparam int PHASE_CODES     = 104;
    // A random code is redrawn when the block would need longer than this.
    // Capping the predicted rounds keeps the cost estimate itself cheap: any
    // code that reaches the cap already costs more than the budget.
    localparam int COST_BUDGET     = 1200;
    localparam int FILTER_ROUNDS   = 240;

    localparam logic [CFG_IDX_W-1:0] MIN_REGS [3] = '{CFG_MIN_X, CFG_MIN_Y, CFG_MIN_Z};
    localparam logic [CFG_IDX_W-1:0] MAX_REGS [3] = '{CFG_MAX_X, CFG_MAX_Y, CFG_MAX_Z};

    // One row of the directed table: either a register write or a code to
    // send. Where the result can be read off at a glance it is typed in and
    // marked as known; every other code row is checked against the predictor.
    typedef enum logic {ROW_CODE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        code_t                value;
        logic                 known;
        code_t                known_fit;
    } table_row_t;

    localparam int DIRECTED_COUNT = 35;

    localparam table_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Reset domain covers every index: codes pass through unchanged.
        '{ROW_CODE,  CFG_MIN_X,     63'h0,                  1'b1, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     CODE_FULL,              1'b1, CODE_FULL},
        '{ROW_CODE,  CFG_MIN_X,     63'h1,                  1'b1, 63'h1},
        '{ROW_CODE,  CFG_MIN_X,     63'h4000_0000_0000_0000, 1'b1, 63'h4000_0000_0000_0000},
        '{ROW_CODE,  CFG_MIN_X,     63'h2AAA_AAAA_AAAA_AAAA, 1'b1, 63'h2AAA_AAAA_AAAA_AAAA},
        '{ROW_CODE,  CFG_MIN_X,     63'h5555_5555_5555_5555, 1'b1, 63'h5555_5555_5555_5555},
        // Box shrunk to the origin on every axis.
        '{ROW_WRITE, CFG_MAX_X,     63'h0,                  1'b0, 63'h0},
        '{ROW_WRITE, CFG_MAX_Y,     63'h0,                  1'b0, 63'h0},
        '{ROW_WRITE, CFG_MAX_Z,     63'h0,                  1'b0, 63'h0},
        // A zero code never exceeds; the full code carries out and wraps to zero.
        '{ROW_CODE,  CFG_MIN_X,     63'h0,                  1'b1, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     CODE_FULL,              1'b1, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     63'h1,                  1'b0, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     63'h1234_5678_9ABC_DEF0, 1'b0, 63'h0},
        // No rounds allowed: the excess stays.
        '{ROW_WRITE, CFG_MAX_STEPS, 63'h0,                  1'b0, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     CODE_FULL,              1'b1, CODE_FULL},
        '{ROW_CODE,  CFG_MIN_X,     63'h1234_5678_9ABC_DEF0, 1'b1, 63'h1234_5678_9ABC_DEF0},
        // A single round, which runs out with the excess partly removed.
        '{ROW_WRITE, CFG_MAX_STEPS, 63'h1,                  1'b0, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     63'h7,                  1'b0, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     63'h6,                  1'b0, 63'h0},
        // Minimum at the top of every axis: everything is clamped to the corner.
        '{ROW_WRITE, CFG_MAX_X,     REG_TOP,                1'b0, 63'h0},
        '{ROW_WRITE, CFG_MAX_Y,     REG_TOP,                1'b0, 63'h0},
        '{ROW_WRITE, CFG_MAX_Z,     REG_TOP,                1'b0, 63'h0},
        '{ROW_WRITE, CFG_MIN_X,     REG_TOP,                1'b0, 63'h0},
        '{ROW_WRITE, CFG_MIN_Y,     REG_TOP,                1'b0, 63'h0},
        '{ROW_WRITE, CFG_MIN_Z,     REG_TOP,                1'b0, 63'h0},
        '{ROW_WRITE, CFG_MAX_STEPS, STEPS_TOP,              1'b0, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     63'h0,                  1'b1, CODE_FULL},
        '{ROW_CODE,  CFG_MIN_X,     CODE_FULL,              1'b1, CODE_FULL},
        // Only x is bounded, with the most rounds allowed.
        '{ROW_WRITE, CFG_MIN_X,     63'h0,                  1'b0, 63'h0},
        '{ROW_WRITE, CFG_MIN_Y,     63'h0,                  1'b0, 63'h0},
        '{ROW_WRITE, CFG_MIN_Z,     63'h0,                  1'b0, 63'h0},
        '{ROW_WRITE, CFG_MAX_X,     63'd1000,               1'b0, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     CODE_FULL,              1'b0, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     63'h0249_2492_4924_9249, 1'b0, 63'h0},
        '{ROW_CODE,  CFG_MIN_X,     63'h0DEA_DBEE_F012_3457, 1'b0, 63'h0}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_X;
    logic [REG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;   // [62:0] code_in, [63] zero
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;          // [62:0] code_out, [63] zero

    // Our own copy of the domain registers, updated as each write is issued.
    logic [REG_W-1:0]   box_min [3];
    logic [REG_W-1:0]   box_max [3];
    logic [STEPS_W-1:0] box_steps;

    // Adjusted codes still owed by the block, oldest first.
    code_t pending_fits [$];

    int unsigned errors         = 0;
    int unsigned codes_sent     = 0;
    int unsigned directed_codes = 0;
    int unsigned skipped_codes  = 0;
    int unsigned results_seen   = 0;
    int unsigned held_stretches = 0;
    int unsigned idle_cycles    = 0;

    // Phases without any idling on either side, and the request for one
    // long receiver hold-off.
    bit burst_mode   = 1'b0;
    bit hold_off_req = 1'b0;

    morton_3d_domain_skip_top #(
        .AXIS_BITS (AXIS_BITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gather one axis index from the interleaved code: bit 3i+axis is bit i.
    function automatic coord_t pick_axis(code_t code, int unsigned axis);
        coord_t      coord;
        int unsigned i;
        for (i = 0; i < AXIS_BITS; i++) begin
            coord[i] = code[3 * i + axis];
        end
        return coord;
    endfunction

    // Scatter one axis index back into the code, leaving the other axes.
    function automatic code_t place_axis(code_t code, int unsigned axis, coord_t coord);
        int unsigned i;
        for (i = 0; i < AXIS_BITS; i++) begin
            code[3 * i + axis] = coord[i];
        end
        return code;
    endfunction

    // Which axes currently lie above their maximum, x in bit 0.
    function automatic logic [2:0] over_flags(code_t code);
        logic [2:0]  over;
        int unsigned a;
        for (a = 0; a < 3; a++) begin
            over[a] = pick_axis(code, a) > box_max[a];
        end
        return over;
    endfunction

    // Predicts the adjusted code under the current domain. Each round steps
    // the exceeding axes in the order x, y, z; a step adds the axis unit at
    // the lowest nonzero octal digit, which moves the code to the next block
    // of the Z-order curve. The sum wraps at the code width. Once the rounds
    // stop, axes below their minimum are raised to it. The round and step
    // counts come back so that the cost of a code can be judged.
    function automatic code_t domain_fit(input code_t code, input int unsigned round_limit,
                                         output int unsigned rounds, output int unsigned steps);
        logic [2:0]  over;
        int unsigned a;
        int unsigned k;
        rounds = 0;
        steps  = 0;
        over   = over_flags(code);
        while (over != 3'b000 && rounds < round_limit) begin
            for (a = 0; a < 3; a++) begin
                if (over[a]) begin
                    k = 0;
                    while (k < AXIS_BITS && code[3 * k +: 3] == 3'b000) k++;
                    if (k < AXIS_BITS) begin
                        code = code + (code_t'(1) << (3 * k + a));
                    end
                    steps++;
                    over = over_flags(code);
                end
            end
            rounds++;
        end
        for (a = 0; a < 3; a++) begin
            if (pick_axis(code, a) < box_min[a]) begin
                code = place_axis(code, a, coord_t'(box_min[a]));
            end
        end
        return code;
    endfunction

    // One register write: driven at one edge, taken at the next.
    task automatic write_domain_reg(input logic [CFG_IDX_W-1:0] index,
                                    input logic [REG_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        case (index)
            CFG_MIN_X:     box_min[0] = data;
            CFG_MIN_Y:     box_min[1] = data;
            CFG_MIN_Z:     box_min[2] = data;
            CFG_MAX_X:     box_max[0] = data;
            CFG_MAX_Y:     box_max[1] = data;
            CFG_MAX_Z:     box_max[2] = data;
            CFG_MAX_STEPS: box_steps  = data[STEPS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Offers one code after a random gap and holds it until the block takes
    // the request. The expectation is queued at acceptance, under the domain
    // then in force.
    task automatic offer_code(input code_t code, input logic known, input code_t known_fit);
        int unsigned pause;
        int unsigned rounds;
        int unsigned steps;
        code_t       fit;
        pause = burst_mode ? 0 : $urandom_range(0, 17);
        if (pause != 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, code};
        do @(posedge aclk); while (s_tready !== 1'b1);
        fit = domain_fit(code, box_steps, rounds, steps);
        pending_fits.insert(pending_fits.size(), known ? known_fit : fit);
        codes_sent++;
        if (rounds != 0) skipped_codes++;
    endtask

    // Stops offering and waits until every result is back, so that the
    // block is idle before the domain changes or the run ends.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (pending_fits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Stimulus: reset, the directed table, then random phases, each under a
    // freshly drawn domain.
    initial begin
        int unsigned row;
        int unsigned phase;
        int unsigned n;
        int unsigned a;
        int unsigned tries;
        int unsigned rounds;
        int unsigned steps;
        int unsigned cap;
        code_t       cand;
        code_t       fit;
        coord_t      coord;

        for (a = 0; a < 3; a++) begin
            box_min[a] = MIN_RESET;
            box_max[a] = MAX_RESET;
        end
        box_steps = STEPS_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < DIRECTED_COUNT; row++) begin
            if (DIRECTED_ROWS[row].kind == ROW_WRITE) begin
                wait_for_idle();
                write_domain_reg(DIRECTED_ROWS[row].index,
                                 DIRECTED_ROWS[row].value[REG_W-1:0]);
            end else begin
                offer_code(DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].known,
                           DIRECTED_ROWS[row].known_fit);
                directed_codes++;
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_for_idle();

            // Minimums are often zero so that the skip is what decides the
            // result; maximums cover the whole range of magnitudes. Shifting
            // a random value right by a random amount spreads them evenly
            // over the orders of magnitude.
            for (a = 0; a < 3; a++) begin
                case ($urandom_range(0, 4))
                    0, 1:    coord = '0;
                    2:       coord = MAX_RESET;
                    default: coord = coord_t'($urandom_range(0, 2097151) >> $urandom_range(0, 20));
                endcase
                write_domain_reg(MIN_REGS[a], coord);
                case ($urandom_range(0, 7))
                    0, 1:    coord = MAX_RESET;
                    2:       coord = '0;
                    default: coord = coord_t'($urandom_range(0, 2097151) >> $urandom_range(0, 20));
                endcase
                write_domain_reg(MAX_REGS[a], coord);
            end
            case ($urandom_range(0, 7))
                0:       write_domain_reg(CFG_MAX_STEPS, '0);
                1:       write_domain_reg(CFG_MAX_STEPS, 21'd1);
                2:       write_domain_reg(CFG_MAX_STEPS, REG_W'(STEPS_RESET));
                3:       write_domain_reg(CFG_MAX_STEPS, STEPS_TOP[REG_W-1:0]);
                4, 5:    write_domain_reg(CFG_MAX_STEPS, REG_W'($urandom_range(2, 12)));
                default: write_domain_reg(CFG_MAX_STEPS, REG_W'($urandom_range(0, 300)));
            endcase
            cap = (box_steps < FILTER_ROUNDS) ? box_steps : FILTER_ROUNDS;

            burst_mode = (phase % 3 == 1);

            for (n = 0; n < PHASE_CODES; n++) begin
                // In phases 1 and 4 the receiver stops for a long stretch while
                // requests keep coming, so the block backs up.
                if (n == 40 && (phase == 1 || phase == 4)) hold_off_req = 1'b1;

                // Half of the codes are built around the box: inside it, just
                // above a maximum, just below a minimum or random on each axis. The
                // rest are wholly random, small, single-bit or nearly full codes.
                tries = 0;
                do begin
                    case ($urandom_range(0, 9))
                        0, 1: cand = code_t'({$urandom, $urandom});
                        7:    cand = code_t'($urandom_range(0, 4095));
                        8:    cand = code_t'(1) << $urandom_range(0, CODE_W - 1);
                        9:    cand = CODE_FULL ^ code_t'($urandom_range(0, 63));
                        default: begin
                            cand = '0;
                            for (a = 0; a < 3; a++) begin
                                case ($urandom_range(0, 3))
                                    0: coord = (box_min[a] <= box_max[a])
                                            ? coord_t'($urandom_range(box_max[a], box_min[a]))
                                            : coord_t'(box_max[a]);
                                    1: coord = box_max[a] + coord_t'($urandom_range(1, 64));
                                    2: coord = box_min[a] - coord_t'($urandom_range(1, 64));
                                    default: coord = coord_t'($urandom);
                                endcase
                                cand = place_axis(cand, a, coord);
                            end
                        end
                    endcase
                    fit = domain_fit(cand, cap, rounds, steps);
                    tries++;
                end while (4 + 3 * rounds + 2 * steps > COST_BUDGET && tries < 16);
                // A zero code never exceeds, so it is always quick.
                if (4 + 3 * rounds + 2 * steps > COST_BUDGET) cand = '0;

                offer_code(cand, 1'b0, '0);
            end
        end

        wait_for_idle();
        burst_mode = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d codes (%0d directed) over %0d random domains; %0d needed skips.",
                 codes_sent, directed_codes, PHASES, skipped_codes);
        $display("Checked %0d results with %0d long receiver hold-offs; %0d mismatches.",
                 results_seen, held_stretches, errors);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Receiver: stalls a random number of cycles before each result (none in
    // burst phases, one long stretch when asked) and checks every result
    // against the oldest expectation.
    initial begin
        int unsigned stall;
        code_t       want;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall        = HOLD_OFF_CYCLES;
                held_stretches++;
            end else begin
                stall = burst_mode ? 0 : $urandom_range(0, 17);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            results_seen++;
            if (pending_fits.size() == 0) begin
                $display("%0t ns: result with no request outstanding, expected none, got %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = pending_fits.pop_front();
                if (m_tdata !== {1'b0, want}) begin
                    $display("%0t ns: code_out mismatch, expected %h, got %h",
                             $time, {1'b0, want}, m_tdata);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a request.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t ns: no request moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending_fits.size());
            $display("testbench: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
